// ===== sv/min_tracking_stack_defines.svh =====
// ---------------------------------------------------------------------------
// Min tracking stack assertion macros
// Shared assertion shorthands, clocked on clk and held off during reset.
// ---------------------------------------------------------------------------
`ifndef MIN_TRACKING_STACK_DEFINES_SVH
`define MIN_TRACKING_STACK_DEFINES_SVH

// Same-cycle implication.
`define MTS_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define MTS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/mts_pkg.sv =====
// ---------------------------------------------------------------------------
// mts_pkg
// Constants and types shared by the min tracking stack.
// ---------------------------------------------------------------------------
package mts_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int ADDR_W      = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
	localparam int DATA_W      = 32;
	localparam int ENTRY_CNT_W = 7;

	localparam logic signed [DATA_W-1:0] EMPTY_MARK = 32'sh7FFF_FFFF;

	localparam logic ACT_PUSH = 1'b0;
	localparam logic ACT_POP  = 1'b1;

	// one stored entry: value and running minimum at push time
	typedef struct packed {
		logic signed [DATA_W-1:0] value;
		logic signed [DATA_W-1:0] run_min;
	} entry_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
		entry_t            data;
	} wr_req_t;

	typedef struct packed {
		logic              en;
		logic [ADDR_W-1:0] addr;
	} rd_req_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic signed [DATA_W-1:0] min_value;
		logic [ENTRY_CNT_W-1:0]   entry_count;
		logic                     is_empty;
		logic                     op_error;
	} result_t;

	typedef enum logic [1:0] {
		S_IDLE  = 2'b01,
		S_FETCH = 2'b10
	} state_t;

endpackage

// ===== sv/mts_if.sv =====
// ---------------------------------------------------------------------------
// Min tracking stack channels
// Request channel (push/pop) and response channel (stack status).
// ---------------------------------------------------------------------------
interface mts_req_if;
	logic               valid;
	logic               ready;
	logic               action;
	logic signed [31:0] push_value;

	modport source (output valid, output action, output push_value, input ready);
	modport sink   (input valid, input action, input push_value, output ready);
endinterface

interface mts_rsp_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] top_value;
	logic signed [31:0] min_value;
	logic [6:0]         entry_count;
	logic               is_empty;
	logic               op_error;

	modport source (output valid, output top_value, output min_value, output entry_count,
		output is_empty, output op_error, input ready);
	modport sink   (input valid, input top_value, input min_value, input entry_count,
		input is_empty, input op_error, output ready);
endinterface

// ===== sv/mts_store.sv =====
// ---------------------------------------------------------------------------
// mts_store
// Entry memory: one write port, one read port, registered read data.
// ---------------------------------------------------------------------------
module mts_store
	import mts_pkg::*;
(
	input  logic    clk,
	input  wr_req_t wr_req,
	input  rd_req_t rd_req,
	output entry_t  rd_data
);

	entry_t mem_q [STACK_DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_req.en) begin
			mem_q[wr_req.addr] <= wr_req.data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_req.en) begin
			rd_data_q <= mem_q[rd_req.addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== sv/min_tracking_stack.sv =====
// ---------------------------------------------------------------------------
// min_tracking_stack
// Bounded stack of signed 32-bit values that reports its running minimum.
// ---------------------------------------------------------------------------
// Usage:
//   req  : one transaction per operation; action 0 pushes push_value,
//          action 1 pops the top entry.
//   rsp  : exactly one transaction per request, carrying the top value,
//          minimum, entry count, empty flag and error flag after the op.
//   An empty stack reports 0x7FFFFFFF as top and minimum. A push on a full
//   stack or a pop on an empty one leaves the stack alone and sets op_error.
// Timing:
//   Push, error cases and a pop that empties the stack: result registered
//   on acceptance, next request taken in the following cycle.
//   A pop that leaves entries behind needs the new top from the entry
//   memory (registered read), so it waits in S_FETCH and no new request is
//   taken meanwhile. Throughput is 1 request per cycle for pushes while rsp.ready is high.
// Reset: arst_n clears the entry count and the response valid; memory
//   contents are left as they are and only entries below the count are read.
// Stall: while a response waits for rsp.ready, no new request is accepted;
//   when it is taken, a new request can be accepted in that same cycle.
// ---------------------------------------------------------------------------
`include "min_tracking_stack_defines.svh"

module min_tracking_stack
	import mts_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	mts_req_if.sink   req,
	mts_rsp_if.source rsp
);

	// control
	state_t             state_q, state_d;
	logic [COUNT_W-1:0] count_q, count_d;
	logic               out_valid_q;

	// cached top entry (valid in S_IDLE while count_q is nonzero)
	logic signed [DATA_W-1:0] top_q, tmin_q;
	logic                     cache_load;
	entry_t                   cache_d;

	// response register
	result_t res_q, res_d;
	logic    res_load;

	// memory ports
	wr_req_t wr_req;
	rd_req_t rd_req;
	entry_t  rd_data;

	logic                     out_free, accept, is_push, full, empty;
	logic signed [DATA_W-1:0] push_min;

	mts_store u_store (
		.clk     (clk),
		.wr_req  (wr_req),
		.rd_req  (rd_req),
		.rd_data (rd_data)
	);

	assign out_free  = !out_valid_q || rsp.ready;
	assign req.ready = (state_q == S_IDLE) && out_free;
	assign accept    = req.valid && req.ready;
	assign is_push   = (req.action == ACT_PUSH);
	assign full      = (count_q == COUNT_W'(STACK_DEPTH));
	assign empty     = (count_q == '0);

	// new minimum only when strictly below the one underneath
	assign push_min = (empty || (req.push_value < tmin_q)) ? req.push_value : tmin_q;

	// new entry goes straight to memory at the current count
	always_comb begin
		wr_req.en           = accept && is_push && !full;
		wr_req.addr         = count_q[ADDR_W-1:0];
		wr_req.data.value   = req.push_value;
		wr_req.data.run_min = push_min;
	end

	// pop with entries remaining: fetch the entry below the top
	always_comb begin
		rd_req.en   = accept && !is_push && (count_q > COUNT_W'(1));
		rd_req.addr = ADDR_W'(count_q - COUNT_W'(2));
	end

	always_comb begin
		state_d           = state_q;
		count_d           = count_q;
		cache_load        = 1'b0;
		cache_d.value     = req.push_value;
		cache_d.run_min   = push_min;
		res_load          = 1'b0;
		res_d.top_value   = top_q;
		res_d.min_value   = tmin_q;
		res_d.entry_count = ENTRY_CNT_W'(count_q);
		res_d.is_empty    = empty;
		res_d.op_error    = 1'b0;

		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (is_push) begin
						res_load = 1'b1;
						if (full) begin
							res_d.op_error = 1'b1;
						end else begin
							count_d           = count_q + COUNT_W'(1);
							cache_load        = 1'b1;
							res_d.top_value   = req.push_value;
							res_d.min_value   = push_min;
							res_d.entry_count = ENTRY_CNT_W'(count_q + COUNT_W'(1));
							res_d.is_empty    = 1'b0;
						end
					end else if (empty) begin
						res_load          = 1'b1;
						res_d.op_error    = 1'b1;
						res_d.top_value   = EMPTY_MARK;
						res_d.min_value   = EMPTY_MARK;
					end else if (count_q == COUNT_W'(1)) begin
						res_load          = 1'b1;
						count_d           = '0;
						res_d.top_value   = EMPTY_MARK;
						res_d.min_value   = EMPTY_MARK;
						res_d.entry_count = '0;
						res_d.is_empty    = 1'b1;
					end else begin
						count_d = count_q - COUNT_W'(1);
						state_d = S_FETCH;
					end
				end
			end
			S_FETCH: begin
				// count_q already decremented; rd_data is the new top
				if (out_free) begin
					res_load        = 1'b1;
					cache_load      = 1'b1;
					cache_d         = rd_data;
					res_d.top_value = rd_data.value;
					res_d.min_value = rd_data.run_min;
					state_d         = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (res_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cache_load) begin
			top_q  <= cache_d.value;
			tmin_q <= cache_d.run_min;
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.top_value   = res_q.top_value;
	assign rsp.min_value   = res_q.min_value;
	assign rsp.entry_count = res_q.entry_count;
	assign rsp.is_empty    = res_q.is_empty;
	assign rsp.op_error    = res_q.op_error;

	// checks
	`MTS_ASSERT_NOW(a_count_bound, 1'b1, count_q <= COUNT_W'(STACK_DEPTH), "count beyond depth")
	`MTS_ASSERT_NOW(a_min_le_top, out_valid_q && !res_q.is_empty, res_q.min_value <= res_q.top_value, "minimum above top")
	`MTS_ASSERT_NOW(a_empty_flag, out_valid_q, res_q.is_empty == (res_q.entry_count == '0), "empty flag mismatch")
	`MTS_ASSERT_NEXT(a_push_count, accept && is_push && !full, count_q == $past(count_q) + COUNT_W'(1), "push did not grow stack")
	`MTS_ASSERT_NEXT(a_fetch_hold, state_q == S_FETCH && !out_free, state_q == S_FETCH && $stable(rd_data), "fetch lost while stalled")

endmodule

// ===== tb/sv/tb_min_tracking_stack.sv =====
// ---------------------------------------------------------------------------
// tb_min_tracking_stack
// Self-checking bench for the min tracking stack. A short table of push/pop
// transactions hits the corner cases first: pops on an empty stack, extreme
// values and ties on the minimum. Random bursts follow, biased towards
// filling and draining so that full and empty are reached often. Every
// response is checked against an in-bench stack model. Table rows with an
// obvious answer are also checked against the typed-in value.
// ---------------------------------------------------------------------------
module tb_min_tracking_stack;
	import mts_pkg::*;

	localparam int RAND_PER_PHASE = 475;     // four phases, roughly 1900 random ops
	localparam int CYCLE_LIMIT    = 250000;  // well above the slowest legal run
	localparam int SETTLE_CYCLES  = 8;       // quiet time after the last response
	localparam int N_DIRECTED     = 25;

	localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
	localparam result_t NO_CHK = '0;

	// one row of the directed table; want is only used when typed is set
	typedef struct packed {
		logic                     action;
		logic signed [DATA_W-1:0] value;
		logic                     typed;
		result_t                  want;
	} dir_row_t;

	// status awaiting its response transaction
	typedef struct {
		result_t pred;
		logic    typed;
		result_t typed_want;
	} status_due_t;

	// Directed table: empty-stack pops, INT_MAX onto an empty stack, INT_MIN
	// ties (not strictly less, so the minimum stays put), unwinding back to
	// empty, small ties, alternating bit patterns and a final underflow.
	localparam dir_row_t DIRECTED_OPS [N_DIRECTED] = '{
		'{ACT_POP,  32'sd0,          1'b1, '{EMPTY_MARK, EMPTY_MARK, 7'd0, 1'b1, 1'b1}},
		'{ACT_PUSH, EMPTY_MARK,      1'b1, '{EMPTY_MARK, EMPTY_MARK, 7'd1, 1'b0, 1'b0}},
		'{ACT_PUSH, INT_MIN,         1'b1, '{INT_MIN, INT_MIN, 7'd2, 1'b0, 1'b0}},
		'{ACT_PUSH, INT_MIN,         1'b1, '{INT_MIN, INT_MIN, 7'd3, 1'b0, 1'b0}},
		'{ACT_PUSH, 32'sd0,          1'b1, '{32'sd0, INT_MIN, 7'd4, 1'b0, 1'b0}},
		'{ACT_PUSH, -32'sd1,         1'b0, NO_CHK},
		'{ACT_POP,  -32'sd1,         1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b1, '{EMPTY_MARK, EMPTY_MARK, 7'd0, 1'b1, 1'b0}},
		'{ACT_POP,  32'sh7FFF_FFFF,  1'b1, '{EMPTY_MARK, EMPTY_MARK, 7'd0, 1'b1, 1'b1}},
		'{ACT_PUSH, 32'sd5,          1'b1, '{32'sd5, 32'sd5, 7'd1, 1'b0, 1'b0}},
		'{ACT_PUSH, 32'sd5,          1'b0, NO_CHK},
		'{ACT_PUSH, 32'sd4,          1'b0, NO_CHK},
		'{ACT_PUSH, 32'sd6,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_PUSH, 32'sh5555_5555,  1'b0, NO_CHK},
		'{ACT_PUSH, 32'shAAAA_AAAA,  1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b0, NO_CHK},
		'{ACT_POP,  32'sd0,          1'b1, '{EMPTY_MARK, EMPTY_MARK, 7'd0, 1'b1, 1'b1}}
	};

	logic clk = 1'b0;
	logic arst_n;

	mts_req_if req_if ();
	mts_rsp_if rsp_if ();

	min_tracking_stack uut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// bench-side copy of the stack
	logic signed [DATA_W-1:0] model_val [STACK_DEPTH];
	logic signed [DATA_W-1:0] model_min [STACK_DEPTH];
	int                       model_fill = 0;

	status_due_t status_due [$];

	// typed expectation travelling with the request currently on the bus
	logic    drv_typed;
	result_t drv_want;

	int send_idle_pct  = 0;
	int rsp_stall_pct  = 0;
	int fail_count     = 0;
	int cycle_count    = 0;
	int n_sent         = 0;
	int n_checked      = 0;
	int n_rejected     = 0;
	int n_full         = 0;

	// Apply one push/pop to the model stack and return the status it yields.
	// A push only takes a new minimum when strictly below the one underneath.
	function automatic result_t model_stack_op(logic action, logic signed [DATA_W-1:0] value);
		result_t                  r;
		logic signed [DATA_W-1:0] new_min;
		r = '0;
		if (action == ACT_PUSH) begin
			if (model_fill >= STACK_DEPTH) begin
				r.op_error = 1'b1;
			end else begin
				new_min = value;
				if (model_fill > 0) begin
					if (!(value < model_min[model_fill-1]))
						new_min = model_min[model_fill-1];
				end
				model_val[model_fill] = value;
				model_min[model_fill] = new_min;
				model_fill++;
			end
		end else if (model_fill == 0) begin
			r.op_error = 1'b1;
		end else begin
			model_fill--;
		end
		if (model_fill > 0) begin
			r.top_value = model_val[model_fill-1];
			r.min_value = model_min[model_fill-1];
		end else begin
			r.top_value = EMPTY_MARK;
			r.min_value = EMPTY_MARK;
		end
		r.entry_count = ENTRY_CNT_W'(model_fill);
		r.is_empty    = (model_fill == 0);
		return r;
	endfunction

	function automatic void check_status(result_t got, result_t want, string src);
		if (got.top_value !== want.top_value) begin
			$error("%s top_value: expected %0d, got %0d", src, want.top_value, got.top_value);
			fail_count++;
		end
		if (got.min_value !== want.min_value) begin
			$error("%s min_value: expected %0d, got %0d", src, want.min_value, got.min_value);
			fail_count++;
		end
		if (got.entry_count !== want.entry_count) begin
			$error("%s entry_count: expected %0d, got %0d", src, want.entry_count,
				got.entry_count);
			fail_count++;
		end
		if (got.is_empty !== want.is_empty) begin
			$error("%s is_empty: expected %0b, got %0b", src, want.is_empty, got.is_empty);
			fail_count++;
		end
		if (got.op_error !== want.op_error) begin
			$error("%s op_error: expected %0b, got %0b", src, want.op_error, got.op_error);
			fail_count++;
		end
	endfunction

	// A fifth of the values come from a narrow band so ties on the minimum are
	// common, with the extremes thrown in now and then and the rest fully random.
	function automatic logic signed [DATA_W-1:0] rand_value();
		int unsigned pick;
		pick = $urandom_range(99);
		if (pick < 20)
			return $signed(32'($urandom_range(16))) - 32'sd8;
		if (pick < 30) begin
			case ($urandom_range(3))
				0:       return INT_MIN;
				1:       return EMPTY_MARK;
				2:       return 32'sd0;
				default: return -32'sd1;
			endcase
		end
		return $signed($urandom);
	endfunction

	// Present one transaction, with optional idle cycles before it, and hold
	// it until accepted. Everything changes on the falling edge.
	task automatic send_op(logic action, logic signed [DATA_W-1:0] value, logic typed,
		result_t want);
		@(negedge clk);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			req_if.valid <= 1'b0;
			@(negedge clk);
		end
		req_if.valid      <= 1'b1;
		req_if.action     <= action;
		req_if.push_value <= value;
		drv_typed         <= typed;
		drv_want          <= want;
		do @(posedge clk); while (!req_if.ready);
		n_sent++;
	endtask

	// Drop valid and hold off until every outstanding status has come back.
	task automatic wait_drained();
		@(negedge clk);
		req_if.valid <= 1'b0;
		while (status_due.size() != 0)
			@(posedge clk);
	endtask

	// Random bursts: push-heavy, pop-heavy, balanced, or a straight run of
	// pushes long enough to hit the full stack and bounce off it.
	task automatic run_random(int n_ops);
		int done;
		int burst;
		int push_pct;
		done = 0;
		while (done < n_ops) begin
			case ($urandom_range(3))
				0:       push_pct = 90;
				1:       push_pct = 10;
				2:       push_pct = 50;
				default: push_pct = 100;
			endcase
			burst = (push_pct == 100) ? STACK_DEPTH + 6 : $urandom_range(10, 60);
			for (int i = 0; i < burst && done < n_ops; i++) begin
				send_op(($urandom_range(99) < push_pct) ? ACT_PUSH : ACT_POP, rand_value(),
					1'b0, NO_CHK);
				done++;
			end
		end
	endtask

	// Receiver back-pressure, redrawn every cycle.
	always @(negedge clk) begin
		rsp_if.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
	end

	// Scoreboard: the response is checked before the request of the same edge
	// is predicted, since a response never belongs to a same-edge request.
	always @(posedge clk) begin : status_monitor
		result_t     got;
		status_due_t due;
		if (arst_n) begin
			if (rsp_if.valid && rsp_if.ready) begin
				got = '{rsp_if.top_value, rsp_if.min_value, rsp_if.entry_count,
					rsp_if.is_empty, rsp_if.op_error};
				if (status_due.size() == 0) begin
					$error("status transaction with no request outstanding");
					fail_count++;
				end else begin
					due = status_due.pop_front();
					check_status(got, due.pred, "model");
					if (due.typed)
						check_status(got, due.typed_want, "table");
					n_checked++;
					if (due.pred.op_error)
						n_rejected++;
					if (due.pred.entry_count == STACK_DEPTH)
						n_full++;
				end
			end
			if (req_if.valid && req_if.ready) begin
				due.pred       = model_stack_op(req_if.action, req_if.push_value);
				due.typed      = drv_typed;
				due.typed_want = drv_want;
				status_due.insert(status_due.size(), due);
			end
		end
	end

	// Watchdog on the whole run.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d statuses outstanding", cycle_count,
				status_due.size());
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		req_if.valid      = 1'b0;
		req_if.action     = ACT_PUSH;
		req_if.push_value = '0;
		rsp_if.ready      = 1'b0;
		drv_typed         = 1'b0;
		drv_want          = NO_CHK;
		arst_n            = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			send_op(DIRECTED_OPS[i].action, DIRECTED_OPS[i].value, DIRECTED_OPS[i].typed,
				DIRECTED_OPS[i].want);
		wait_drained();

		// phases: flat out, sender gaps, receiver stalls, then a little of both
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
				1:       begin send_idle_pct = 57; rsp_stall_pct = 0;  end
				2:       begin send_idle_pct = 0;  rsp_stall_pct = 57; end
				default: begin send_idle_pct = 16; rsp_stall_pct = 16; end
			endcase
			run_random(RAND_PER_PHASE);
			wait_drained();
		end

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("Ran %0d push/pop transactions, %0d statuses checked in %0d cycles;",
			n_sent, n_checked, cycle_count);
		$display("%0d rejected ops (underflow/overflow), full stack seen %0d times.",
			n_rejected, n_full);
		if (fail_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
